[src/tdoa_direction_angles_macros.svh]
// Assertion macros for the direction-angle block.
`ifndef TDOA_DIRECTION_ANGLES_MACROS_SVH
`define TDOA_DIRECTION_ANGLES_MACROS_SVH

// Clocked check, masked while reset is high.
`define TDOA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TDOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tdoa_pkg.sv]
`timescale 1ns / 1ps
package tdoa_pkg;

  localparam int LAG_BITS     = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int COEF_W       = 22;
  localparam int PROD_W       = COEF_W + LAG_BITS;
  localparam int V_W          = PROD_W + 3;
  localparam int GAIN_W       = 18;
  localparam int ZK_W         = V_W + GAIN_W;
  localparam int CW           = V_W + 22;
  localparam int ANG_W        = 26;
  localparam int ELEV_W       = 15;
  localparam int AZIM_W       = 16;
  localparam int MAG_SH       = 16;
  localparam int UNIT_SH      = 9;
  localparam int ROUND_BIAS   = 256;
  localparam int OUT_MAX      = 23040;
  localparam int ANG_HALF     = 180 * 65536;

  typedef logic signed [LAG_BITS-1:0] lag_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [V_W-1:0]      vec_t;
  typedef logic signed [ZK_W-1:0]     zk_t;
  typedef logic signed [CW-1:0]       cw_t;
  typedef logic signed [ANG_W-1:0]    ang_t;
  typedef logic signed [AZIM_W-1:0]   azim_t;

  // 3x6 pseudo-inverse, row-major, 8 fraction bits
  localparam coef_t COEF [18] = '{
    coef_t'(-292949), coef_t'(-585899), coef_t'(-292949),
    coef_t'(-292949), coef_t'(0),       coef_t'(292949),
    coef_t'(507403),  coef_t'(0),       coef_t'(169134),
    coef_t'(-507403), coef_t'(-338269), coef_t'(169134),
    coef_t'(0),       coef_t'(0),       coef_t'(131011),
    coef_t'(0),       coef_t'(131011),  coef_t'(131011)
  };

  localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 18'sd107923;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam ang_t ATAN_DEG [TAB_LEN] = '{
    ang_t'(2949120), ang_t'(1740967), ang_t'(919879), ang_t'(466945),
    ang_t'(234379),  ang_t'(117304),  ang_t'(58666),  ang_t'(29335),
    ang_t'(14668),   ang_t'(7334),    ang_t'(3667),   ang_t'(1833),
    ang_t'(917),     ang_t'(458),     ang_t'(229),    ang_t'(115),
    ang_t'(57),      ang_t'(29),      ang_t'(14),     ang_t'(7),
    ang_t'(4),       ang_t'(2),       ang_t'(1),      ang_t'(0)
  };

  typedef struct packed {
    logic signed [CW-1:0]    a;
    logic signed [CW-1:0]    b;
    logic signed [ANG_W-1:0] ang;
  } cord_t;

  // sideband that rides along the CORDIC pipes
  typedef struct packed {
    logic signed [ZK_W-1:0]   zk;
    logic signed [AZIM_W-1:0] azim;
    logic                     zero;
    logic                     mzero;
    logic                     zpos;
  } side_t;

  // Q16 degrees to 1/128 degree, rounded, clamped
  function automatic azim_t to_units(ang_t ang, logic elev);
    ang_t q;
    ang_t lo;
    ang_t hi;
    q  = (ang + ang_t'(ROUND_BIAS)) >>> UNIT_SH;
    lo = elev ? ang_t'(0) : ang_t'(-OUT_MAX);
    hi = ang_t'(OUT_MAX);
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return azim_t'(q);
  endfunction

endpackage

[src/tdoa_lag_if.sv]
`timescale 1ns / 1ps
interface tdoa_lag_if import tdoa_pkg::*; ();
  logic valid;
  logic ready;
  lag_t lag_01;
  lag_t lag_02;
  lag_t lag_03;
  lag_t lag_12;
  lag_t lag_13;
  lag_t lag_23;

  modport source (output valid, lag_01, lag_02, lag_03, lag_12, lag_13, lag_23,
                  input ready);
  modport sink (input valid, lag_01, lag_02, lag_03, lag_12, lag_13, lag_23,
                output ready);
endinterface

[src/tdoa_ang_if.sv]
`timescale 1ns / 1ps
interface tdoa_ang_if import tdoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEV_W-1:0] elevation;
  azim_t             azimuth;
  logic              zero_vector;

  modport source (output valid, elevation, azimuth, zero_vector, input ready);
  modport sink (input valid, elevation, azimuth, zero_vector, output ready);
endinterface

[src/tdoa_matmul.sv]
`timescale 1ns / 1ps
module tdoa_matmul import tdoa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  lag_t lag [6],
  output logic v_valid,
  output vec_t v [3]
);

  prod_t prod [18];
  logic  prod_valid;
  vec_t  v_next [3];

  // stage 1: constant products
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 6; k++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) prod[r*6+k] <= prod_t'(COEF[r*6+k]) * prod_t'(lag[k]);
      end
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v_next[r] = '0;
      for (int k = 0; k < 6; k++) v_next[r] = v_next[r] + vec_t'(prod[r*6+k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) v <= v_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      v_valid    <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      v_valid    <= prod_valid;
    end
  end

endmodule

[src/tdoa_cordic.sv]
`timescale 1ns / 1ps
module tdoa_cordic import tdoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  cord_t in_c,
  input  side_t in_s,
  output logic  out_valid,
  output cord_t out_c,
  output side_t out_s
);

  cord_t c   [CORDIC_STEPS+1];
  side_t s   [CORDIC_STEPS+1];
  logic  vld [CORDIC_STEPS+1];
  cord_t pre;

  // fold left half-plane into the right, start angle at +/-180
  always_comb begin
    pre = in_c;
    if (in_c.b < 0) begin
      pre.ang = (in_c.a >= 0) ? ang_t'(ANG_HALF) : ang_t'(-ANG_HALF);
      pre.a   = -in_c.a;
      pre.b   = -in_c.b;
    end else begin
      pre.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c[0] <= pre;
      s[0] <= in_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cord_t nx;
    always_comb begin
      if (c[i].a >= 0) begin
        nx.b   = c[i].b + (c[i].a >>> i);
        nx.a   = c[i].a - (c[i].b >>> i);
        nx.ang = c[i].ang + ATAN_DEG[i];
      end else begin
        nx.b   = c[i].b - (c[i].a >>> i);
        nx.a   = c[i].a + (c[i].b >>> i);
        nx.ang = c[i].ang - ATAN_DEG[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c[i+1] <= nx;
        s[i+1] <= s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_c     = c[CORDIC_STEPS];
  assign out_s     = s[CORDIC_STEPS];

endmodule

[src/tdoa_direction_angles.sv]
`timescale 1ns / 1ps
// Channel  Dir  Word contents
// lags     in   lag_01 lag_02 lag_03 lag_12 lag_13 lag_23 (signed)
// angles   out  elevation, azimuth (1/128 deg), zero_vector
//
// One word accepted per cycle while the output is not stalled; the latency is set
// by the two CORDIC pipes of one rotation stage per step.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// A stall at the output freezes every stage at once; lags.ready follows.
module tdoa_direction_angles import tdoa_pkg::*; (
  input logic         clk,
  input logic         rst,
  tdoa_lag_if.sink    lags,
  tdoa_ang_if.source  angles
);

  logic  en;
  lag_t  lag [6];
  logic  v_valid;
  vec_t  v [3];

  // prep stage
  logic  p_valid;
  cord_t p_c;
  side_t p_s;

  // azimuth pipe
  logic  az_valid;
  cord_t az_c;
  side_t az_s;

  // conversion stage feeding elevation pipe
  logic  e_valid;
  cord_t e_c;
  side_t e_s;

  // elevation pipe
  logic  el_valid;
  cord_t el_c;
  side_t el_s;

  logic  o_valid;

  // whole pipe advances when the output register can take a word
  assign en          = !o_valid || angles.ready;
  assign lags.ready  = en;
  assign angles.valid = o_valid;

  assign lag[0] = lags.lag_01;
  assign lag[1] = lags.lag_02;
  assign lag[2] = lags.lag_03;
  assign lag[3] = lags.lag_12;
  assign lag[4] = lags.lag_13;
  assign lag[5] = lags.lag_23;

  tdoa_matmul u_matmul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (lags.valid),
    .lag      (lag),
    .v_valid  (v_valid),
    .v        (v)
  );

  // z scaled by CORDIC gain; azimuth vector is (b=y, a=x)
  always_ff @(posedge clk) begin
    if (en) begin
      p_c.a     <= cw_t'(v[0]);
      p_c.b     <= cw_t'(v[1]);
      p_c.ang   <= '0;
      p_s.zk    <= zk_t'(v[2]) * zk_t'(GAIN_Q16);
      p_s.azim  <= '0;
      p_s.zero  <= (v[0] == 0) && (v[1] == 0) && (v[2] == 0);
      p_s.mzero <= (v[0] == 0) && (v[1] == 0);
      p_s.zpos  <= v[2] > 0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= v_valid;
  end

  tdoa_cordic u_az (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_c      (p_c),
    .in_s      (p_s),
    .out_valid (az_valid),
    .out_c     (az_c),
    .out_s     (az_s)
  );

  // azimuth in output units; elevation vector is (b=zk, a=m<<16)
  always_ff @(posedge clk) begin
    if (en) begin
      e_c.a     <= az_c.b <<< MAG_SH;
      e_c.b     <= cw_t'(az_s.zk);
      e_c.ang   <= '0;
      e_s.zk    <= az_s.zk;
      e_s.azim  <= az_s.mzero ? azim_t'(0) : to_units(az_c.ang, 1'b0);
      e_s.zero  <= az_s.zero;
      e_s.mzero <= az_s.mzero || (az_c.b == 0);
      e_s.zpos  <= az_s.zpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (en) e_valid <= az_valid;
  end

  tdoa_cordic u_el (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_c      (e_c),
    .in_s      (e_s),
    .out_valid (el_valid),
    .out_c     (el_c),
    .out_s     (el_s)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      angles.zero_vector <= el_s.zero;
      if (el_s.zero) begin
        angles.elevation <= ELEV_W'(OUT_MAX);
        angles.azimuth   <= '0;
      end else begin
        angles.azimuth <= el_s.azim;
        if (el_s.mzero) begin
          // on the z axis: straight up or straight down
          angles.elevation <= el_s.zpos ? ELEV_W'(0) : ELEV_W'(OUT_MAX);
        end else begin
          angles.elevation <= ELEV_W'(to_units(el_c.ang, 1'b1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (en) o_valid <= el_valid;
  end

endmodule

[src/tdoa_checker.sv]
`timescale 1ns / 1ps
`include "tdoa_direction_angles_macros.svh"
module tdoa_checker import tdoa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ELEV_W-1:0] elevation,
  input azim_t             azimuth,
  input logic              zero_vector
);

  `TDOA_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(elevation) && $stable(azimuth) && $stable(zero_vector), "stalled word changed")
  `TDOA_ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "valid after reset")
  `TDOA_ASSERT(a_ready, clk, rst, in_ready == (!out_valid || out_ready), "input ready mismatch")
  `TDOA_ASSERT(a_zero, clk, rst, out_valid && zero_vector |-> elevation == ELEV_W'(OUT_MAX) && azimuth == 0, "zero vector angles")
  `TDOA_ASSERT(a_range, clk, rst, out_valid |-> elevation <= ELEV_W'(OUT_MAX) && azimuth <= azim_t'(OUT_MAX) && azimuth >= azim_t'(-OUT_MAX), "angle out of range")

endmodule

bind tdoa_direction_angles tdoa_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (lags.ready),
  .out_valid   (angles.valid),
  .out_ready   (angles.ready),
  .elevation   (angles.elevation),
  .azimuth     (angles.azimuth),
  .zero_vector (angles.zero_vector)
);

[sim/tdoa_direction_angles_test.sv]
`timescale 1ns / 1ps
// Testbench for the direction-angle block: lag words in, elevation/azimuth words out.
module tdoa_direction_angles_test;
  import tdoa_pkg::*;

  // Word on the lag channel, kept in the order the bus carries it.
  typedef struct packed {
    lag_t l01;
    lag_t l02;
    lag_t l03;
    lag_t l12;
    lag_t l13;
    lag_t l23;
  } lag_word_t;

  // Word on the angle channel.
  typedef struct packed {
    logic [ELEV_W-1:0] elev;
    logic [15:0]       azim;
    logic              zero;
  } angle_word_t;

  localparam int TOTAL_WORDS = 550;
  localparam int HANG_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 2 * CORDIC_STEPS + 20;

  // Pseudo-inverse coefficients, row-major 3x6, 8 fraction bits.
  localparam longint PINV [18] = '{
    -292949, -585899, -292949, -292949, 0, 292949,
    507403, 0, 169134, -507403, -338269, 169134,
    0, 0, 131011, 0, 131011, 131011
  };
  // atan(2^-i) in degrees, 16 fraction bits.
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk;
  logic rst;

  tdoa_lag_if lags ();
  tdoa_ang_if angles ();

  tdoa_direction_angles uut (
    .clk    (clk),
    .rst    (rst),
    .lags   (lags.sink),
    .angles (angles.source)
  );

  lag_word_t   pending_lags[$];
  angle_word_t expected_angles[$];

  int mismatches;
  int words_sent;
  int words_seen;
  int zero_hits;
  int axis_hits;
  int idle_cycles;
  bit stim_loaded;

  // handshakes seen at the last rising edge
  bit lag_taken;
  bit ang_taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Vectoring CORDIC on (b, a); gives angle in Q16 degrees, magnitude*gain in mag.
  function automatic longint cordic_vector(longint a, longint b, output longint mag);
    longint ang;
    longint da;
    longint db;
    ang = 0;
    if (b < 0) begin
      ang = (a >= 0) ? 180 * 65536 : -180 * 65536;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (a >= 0) begin
        b += da;
        a -= db;
        ang += ATAN_Q16[i];
      end else begin
        b -= da;
        a += db;
        ang -= ATAN_Q16[i];
      end
    end
    mag = b;
    return ang;
  endfunction

  function automatic longint to_deg128(longint ang, longint lo, longint hi);
    longint q;
    q = (ang + 256) >>> 9;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic angle_word_t predict_angles(lag_word_t w);
    longint lag [6];
    longint v [3];
    longint m;
    longint dummy;
    longint el;
    longint az;
    angle_word_t r;
    lag = '{longint'(w.l01), longint'(w.l02), longint'(w.l03),
            longint'(w.l12), longint'(w.l13), longint'(w.l23)};
    for (int row = 0; row < 3; row++) begin
      v[row] = 0;
      for (int k = 0; k < 6; k++) v[row] += PINV[row * 6 + k] * lag[k];
    end
    m = 0;
    r.zero = 1'b0;
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      r.zero = 1'b1;
      el = OUT_MAX;
      az = 0;
    end else begin
      if (v[0] == 0 && v[1] == 0) az = 0;
      else az = to_deg128(cordic_vector(v[0], v[1], m), -OUT_MAX, OUT_MAX);
      if (m == 0) el = (v[2] > 0) ? 0 : OUT_MAX;
      else el = to_deg128(cordic_vector(m * 65536, v[2] * 107923, dummy), 0, OUT_MAX);
    end
    r.elev = el[ELEV_W-1:0];
    r.azim = az[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", words_seen, what, got, want);
  endtask

  function automatic lag_word_t lw(int a, int b, int c, int d, int e, int f);
    lag_word_t w;
    w = '{lag_t'(a), lag_t'(b), lag_t'(c), lag_t'(d), lag_t'(e), lag_t'(f)};
    return w;
  endfunction

  // Lags from a consistent set of arrival times, plus small noise.
  function automatic lag_word_t geometric_word();
    int t [4];
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) t[i] = $urandom_range(0, 60) - 30;
    return lw(t[1] - t[0] + n - 1, t[2] - t[0], t[3] - t[0],
              t[2] - t[1], t[3] - t[1], t[3] - t[2]);
  endfunction

  // Directed words, then mostly geometric words and some raw noise.
  initial begin
    int r;
    pending_lags.push_back(lw(0, 0, 0, 0, 0, 0));         // zero vector
    pending_lags.push_back(lw(127, 127, 127, 127, 127, 127));
    pending_lags.push_back(lw(-128, -128, -128, -128, -128, -128));
    pending_lags.push_back(lw(127, -128, 127, -128, 127, -128));
    pending_lags.push_back(lw(-128, 127, -128, 127, -128, 127));
    pending_lags.push_back(lw(0, 0, 1, 0, 0, 0));         // lag_03 alone, z>0
    pending_lags.push_back(lw(0, 0, -1, 0, 0, 0));        // lag_03 alone, z<0
    pending_lags.push_back(lw(0, 0, 0, 0, 0, 1));
    pending_lags.push_back(lw(0, 0, 0, 0, 0, -1));
    pending_lags.push_back(lw(1, 0, 0, 0, 0, 0));
    pending_lags.push_back(lw(-1, 0, 0, 0, 0, 0));
    pending_lags.push_back(lw(0, 1, 0, 0, 0, 0));
    pending_lags.push_back(lw(0, 0, 0, 1, 0, 0));
    pending_lags.push_back(lw(0, 0, 0, 0, 1, 0));
    pending_lags.push_back(lw(0, 0, 0, -1, 0, 0));
    pending_lags.push_back(lw(-1, -1, 0, 0, 0, 0));
    pending_lags.push_back(lw(127, 0, 0, 0, 0, 0));
    pending_lags.push_back(lw(-128, 0, 0, 0, 0, 0));
    pending_lags.push_back(lw(1, 2, 1, 1, 0, -1));        // consistent arrival-time pattern
    pending_lags.push_back(lw(85, 0, -42, -85, -127, -42));
    while (pending_lags.size() < TOTAL_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 6) pending_lags.push_back(geometric_word());
      else if (r < 7) pending_lags.push_back(lw(0, 0, $urandom, 0, $urandom, $urandom));
      else pending_lags.push_back(lag_word_t'({$urandom, $urandom}));
    end
    stim_loaded = 1'b1;
  end

  always @(posedge clk) begin
    lag_taken <= lags.valid && lags.ready;
    ang_taken <= angles.valid && angles.ready;
  end

  // Driver: one word at a time, random gap between words, changes on falling edge.
  int send_gap;
  initial begin
    lags.valid  = 1'b0;
    lags.lag_01 = '0;
    lags.lag_02 = '0;
    lags.lag_03 = '0;
    lags.lag_12 = '0;
    lags.lag_13 = '0;
    lags.lag_23 = '0;
    angles.ready = 1'b0;
    send_gap = 0;
  end

  always @(negedge clk) begin
    if (rst) begin
      lags.valid <= 1'b0;
    end else if (lags.valid && !lag_taken) begin
      // hold the word until taken
    end else if (send_gap > 0) begin
      lags.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (stim_loaded && pending_lags.size() > 0) begin
      lag_word_t w;
      w = pending_lags.pop_front();
      lags.valid  <= 1'b1;
      lags.lag_01 <= w.l01;
      lags.lag_02 <= w.l02;
      lags.lag_03 <= w.l03;
      lags.lag_12 <= w.l12;
      lags.lag_13 <= w.l13;
      lags.lag_23 <= w.l23;
      // no gap before the next word in at least a quarter of cases
      send_gap <= (($urandom_range(0, 3) == 0)) ? 0 : $urandom_range(0, 17);
    end else begin
      lags.valid <= 1'b0;
    end
  end

  // Sink stall: draw a wait per word, then raise ready.
  int recv_wait;
  initial recv_wait = 0;
  always @(negedge clk) begin
    if (rst) begin
      angles.ready <= 1'b0;
    end else if (ang_taken) begin
      int w;
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      angles.ready <= (w == 0);
      recv_wait <= (w > 0) ? w - 1 : 0;
    end else if (recv_wait > 0) begin
      angles.ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      angles.ready <= 1'b1;
    end
  end

  // Monitor: predict on input accept, compare on output accept.
  always @(posedge clk) begin
    if (!rst) begin
      if ((lags.valid && lags.ready) || (angles.valid && angles.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (lags.valid && lags.ready) begin
        angle_word_t e;
        e = predict_angles('{lags.lag_01, lags.lag_02, lags.lag_03,
                             lags.lag_12, lags.lag_13, lags.lag_23});
        expected_angles.push_back(e);
        words_sent++;
        if (e.zero) zero_hits++;
      end
      if (angles.valid && angles.ready) begin
        words_seen++;
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          angle_word_t e;
          e = expected_angles.pop_front();
          if (angles.elevation !== e.elev)
            report_mismatch("elevation", angles.elevation, e.elev);
          if (angles.azimuth !== e.azim)
            report_mismatch("azimuth", $signed(angles.azimuth), $signed(e.azim));
          if (angles.zero_vector !== e.zero)
            report_mismatch("zero_vector", angles.zero_vector, e.zero);
          if (!e.zero && e.azim == 0) axis_hits++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= HANG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", HANG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mismatches  = 0;
    words_sent  = 0;
    words_seen  = 0;
    zero_hits   = 0;
    axis_hits   = 0;
    idle_cycles = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (stim_loaded && pending_lags.size() == 0 && !lags.valid);
    wait (expected_angles.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d lag words, %0d angle words checked", words_sent, words_seen);
    $display("Zero vectors: %0d, zero-azimuth results: %0d", zero_hits, axis_hits);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tdoa_pkg.sv
src/tdoa_lag_if.sv
src/tdoa_ang_if.sv
src/tdoa_matmul.sv
src/tdoa_cordic.sv
src/tdoa_direction_angles.sv
src/tdoa_checker.sv
sim/tdoa_direction_angles_test.sv
